[design/ast_pkg.sv]
package ast_pkg;

  localparam int VALUE_BITS  = 16;
  localparam int OFFSET_BITS = 16;

  typedef enum logic [3:0] {
    K_MNEMONIC = 4'd0,
    K_LABEL    = 4'd1,
    K_ALIAS    = 4'd2,
    K_NUMBER   = 4'd3,
    K_DIRECTIVE = 4'd4,
    K_COMMENT  = 4'd5,
    K_OPEN     = 4'd6,
    K_CLOSE    = 4'd7,
    K_EQUALS   = 4'd8,
    K_HASH     = 4'd9,
    K_ERROR    = 4'd10,
    K_END      = 4'd11,
    K_ALIASDEF = 4'd12
  } kind_t;

  typedef enum logic [2:0] {
    M_IDLE      = 3'd0,
    M_NUMBER    = 3'd1,
    M_NAME      = 3'd2,
    M_DIRECTIVE = 3'd3,
    M_COMMENT   = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    B_DEC = 2'd0,
    B_HEX = 2'd1,
    B_BIN = 2'd2
  } base_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_EQ     = 8'h3d;
  localparam logic [7:0] CH_OPEN   = 8'h28;
  localparam logic [7:0] CH_CLOSE  = 8'h29;
  localparam logic [7:0] CH_UNDER  = 8'h5f;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] value;
    logic [15:0] start;
    logic [7:0]  count;
    logic [15:0] row;
    logic [15:0] column;
  } result_t;

  localparam logic [23:0] MNEMONICS [56] = '{
    "LDA","LDX","LDY","STA","STX","STY","TAX","TAY","TSX","TXA","TXS","TYA",
    "PHA","PHP","PLA","PLP","AND","EOR","ORA","BIT","ADC","SBC","CMP","CPX",
    "CPY","INC","INX","INY","DEC","DEX","DEY","ASL","LSR","ROL","ROR","JMP",
    "JSR","RTS","BCC","BCS","BEQ","BMI","BNE","BPL","BVC","BVS","CLC","CLD",
    "CLI","CLV","SEC","SED","SEI","BRK","NOP","RTI"
  };

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == CH_UNDER;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [4:0] d;
    d = 5'd31;
    if (is_digit(c)) d = 5'(c - "0");
    else if (c >= "a" && c <= "f") d = 5'(c - "a" + 8'd10);
    else if (c >= "A" && c <= "F") d = 5'(c - "A" + 8'd10);
    return d;
  endfunction

  function automatic logic mnemonic_hit(input logic [23:0] p);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < 56; i++) begin
      if (MNEMONICS[i] == p) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

[design/ast_lexer.sv]
module ast_lexer (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          c,
  output ast_pkg::result_t    res [3],
  output logic [1:0]          res_n
);
  import ast_pkg::*;

  mode_t       scan_mode;
  base_t       number_base;
  logic        negative_sign;
  logic        digit_seen;
  logic [15:0] acc;
  logic [23:0] name_prefix;
  logic [15:0] tok_start, tok_row, tok_col, cur_row, cur_col, byte_offset;
  logic [7:0]  tok_count;
  logic [3:0]  previous_kind;
  result_t     earlier;

  mode_t       scan_mode_next;
  base_t       number_base_next;
  logic        negative_sign_next, digit_seen_next;
  logic [15:0] acc_next;
  logic [23:0] name_prefix_next;
  logic [15:0] tok_start_next, tok_row_next, tok_col_next;
  logic [15:0] cur_row_next, cur_col_next, byte_offset_next;
  logic [7:0]  tok_count_next;
  logic [3:0]  previous_kind_next;
  result_t     earlier_next;

  logic        consumed;
  logic [4:0]  d;
  logic [4:0]  radix;
  logic [15:0] v;
  logic [7:0]  grown;
  result_t     span;

  always_comb begin
    res[0] = '0;
    res[1] = '0;
    res[2] = '0;
    res_n = 2'd0;
    scan_mode_next = scan_mode;
    number_base_next = number_base;
    negative_sign_next = negative_sign;
    digit_seen_next = digit_seen;
    acc_next = acc;
    name_prefix_next = name_prefix;
    tok_start_next = tok_start;
    tok_row_next = tok_row;
    tok_col_next = tok_col;
    tok_count_next = tok_count;
    cur_row_next = cur_row;
    cur_col_next = cur_col;
    byte_offset_next = byte_offset;
    previous_kind_next = previous_kind;
    earlier_next = earlier;
    consumed = 1'b0;
    d = digit_of(c);
    radix = (number_base == B_HEX) ? 5'd16 : ((number_base == B_BIN) ? 5'd2 : 5'd10);
    v = negative_sign ? 16'(-acc) : acc;
    grown = (tok_count < 8'd255) ? tok_count + 8'd1 : tok_count;
    span = '{kind: 4'd0, value: 16'd0, start: tok_start, count: tok_count,
             row: tok_row, column: tok_col};

    unique case (scan_mode)
      M_NUMBER: begin
        if (d < radix) begin
          acc_next = 16'(acc * radix) + 16'(d);
          digit_seen_next = 1'b1;
          tok_count_next = grown;
          consumed = 1'b1;
        end else begin
          scan_mode_next = M_IDLE;
          res[0] = span;
          res_n = 2'd1;
          if (number_base == B_DEC && negative_sign && !digit_seen) begin
            res[0].kind = K_ERROR;
            previous_kind_next = K_ERROR;
          end else begin
            res[0].kind = K_NUMBER;
            res[0].value = v;
            previous_kind_next = K_NUMBER;
            if (previous_kind == K_EQUALS) begin
              res[1] = earlier;
              res[1].kind = K_ALIASDEF;
              res[1].value = v;
              res_n = 2'd2;
            end
          end
        end
      end
      M_NAME: begin
        if (is_word(c)) begin
          if (tok_count < 8'd3) name_prefix_next = {name_prefix[15:0], c};
          tok_count_next = grown;
          consumed = 1'b1;
        end else begin
          scan_mode_next = M_IDLE;
          res[0] = span;
          res_n = 2'd1;
          if (tok_count == 8'd3 && mnemonic_hit(name_prefix)) begin
            res[0].kind = K_MNEMONIC;
          end else if (c == CH_COLON) begin
            res[0].kind = K_LABEL;
            consumed = 1'b1;
          end else begin
            res[0].kind = K_ALIAS;
          end
          previous_kind_next = res[0].kind;
        end
      end
      M_DIRECTIVE: begin
        if (is_word(c)) begin
          tok_count_next = grown;
          consumed = 1'b1;
        end else begin
          scan_mode_next = M_IDLE;
          res[0] = span;
          res[0].kind = K_DIRECTIVE;
          res_n = 2'd1;
          previous_kind_next = K_DIRECTIVE;
        end
      end
      M_COMMENT: begin
        if (c != CH_NL && c != CH_NUL) begin
          tok_count_next = grown;
          consumed = 1'b1;
        end else begin
          scan_mode_next = M_IDLE;
          res[0] = span;
          res[0].kind = K_COMMENT;
          res_n = 2'd1;
          previous_kind_next = K_COMMENT;
          consumed = (c == CH_NL);
        end
      end
      default: ;
    endcase

    if (c == CH_NUL) begin
      res[res_n] = '{kind: K_END, value: 16'd0, start: byte_offset, count: 8'd0,
                     row: cur_row, column: cur_col};
      res_n = res_n + 2'd1;
      scan_mode_next = M_IDLE;
      number_base_next = B_DEC;
      negative_sign_next = 1'b0;
      digit_seen_next = 1'b0;
      acc_next = '0;
      name_prefix_next = '0;
      tok_start_next = '0;
      tok_count_next = '0;
      tok_row_next = 16'd1;
      tok_col_next = 16'd1;
      cur_row_next = 16'd1;
      cur_col_next = 16'd1;
      byte_offset_next = '0;
      previous_kind_next = K_ERROR;
      earlier_next = '0;
    end else begin
      if (!consumed && !is_space(c)) begin
        tok_start_next = byte_offset;
        tok_count_next = 8'd1;
        tok_row_next = cur_row;
        tok_col_next = cur_col;
        if (c == CH_DOLLAR || c == CH_PCT || c == CH_MINUS || is_digit(c)) begin
          scan_mode_next = M_NUMBER;
          number_base_next = (c == CH_DOLLAR) ? B_HEX : ((c == CH_PCT) ? B_BIN : B_DEC);
          negative_sign_next = (c == CH_MINUS);
          digit_seen_next = is_digit(c);
          acc_next = is_digit(c) ? 16'(c - "0") : 16'd0;
        end else if (c == CH_DOT) begin
          scan_mode_next = M_DIRECTIVE;
        end else if (is_alpha(c) || c == CH_UNDER) begin
          scan_mode_next = M_NAME;
          name_prefix_next = {16'd0, c};
        end else if (c == CH_SEMI) begin
          scan_mode_next = M_COMMENT;
        end else begin
          res[res_n] = '{kind: K_ERROR, value: 16'd0, start: byte_offset, count: 8'd1,
                         row: cur_row, column: cur_col};
          case (c)
            CH_OPEN:  res[res_n].kind = K_OPEN;
            CH_CLOSE: res[res_n].kind = K_CLOSE;
            CH_HASH:  res[res_n].kind = K_HASH;
            CH_EQ: begin
              res[res_n].kind = K_EQUALS;
              earlier_next = span;
            end
            default: ;
          endcase
          previous_kind_next = res[res_n].kind;
          res_n = res_n + 2'd1;
        end
      end
      byte_offset_next = byte_offset + 16'd1;
      if (c == CH_NL) begin
        cur_row_next = (cur_row != 16'hffff) ? cur_row + 16'd1 : cur_row;
        cur_col_next = 16'd1;
      end else begin
        cur_col_next = (cur_col != 16'hffff) ? cur_col + 16'd1 : cur_col;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode <= M_IDLE;
      number_base <= B_DEC;
      negative_sign <= 1'b0;
      digit_seen <= 1'b0;
      acc <= '0;
      name_prefix <= '0;
      tok_start <= '0;
      tok_count <= '0;
      tok_row <= 16'd1;
      tok_col <= 16'd1;
      cur_row <= 16'd1;
      cur_col <= 16'd1;
      byte_offset <= '0;
      previous_kind <= K_ERROR;
      earlier <= '0;
    end else if (step) begin
      scan_mode <= scan_mode_next;
      number_base <= number_base_next;
      negative_sign <= negative_sign_next;
      digit_seen <= digit_seen_next;
      acc <= acc_next;
      name_prefix <= name_prefix_next;
      tok_start <= tok_start_next;
      tok_count <= tok_count_next;
      tok_row <= tok_row_next;
      tok_col <= tok_col_next;
      cur_row <= cur_row_next;
      cur_col <= cur_col_next;
      byte_offset <= byte_offset_next;
      previous_kind <= previous_kind_next;
      earlier <= earlier_next;
    end
  end

endmodule

[design/ast_outq.sv]
module ast_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ast_pkg::result_t wr [3],
  input  logic [1:0]       wr_n,
  output logic             space_ok,
  output logic             out_valid,
  input  logic             out_stall,
  output ast_pkg::result_t out_res,
  output logic             out_last
);
  import ast_pkg::*;

  result_t    mem [8];
  logic       last_mem [8];
  logic [2:0] wp, rp;
  logic [3:0] fill;
  logic       pop;
  logic [3:0] fill_next;

  assign pop = out_valid && !out_stall;
  assign out_valid = fill != 4'd0;
  assign out_res = mem[rp];
  assign out_last = last_mem[rp];
  assign space_ok = fill <= 4'd5;
  assign fill_next = fill + (push ? {2'd0, wr_n} : 4'd0) - (pop ? 4'd1 : 4'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      fill <= '0;
    end else begin
      if (push) wp <= wp + 3'(wr_n);
      if (pop) rp <= rp + 3'd1;
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < wr_n) begin
          mem[wp + 3'(i)] <= wr[i];
          last_mem[wp + 3'(i)] <= (2'(i) == wr_n - 2'd1);
        end
      end
    end
  end

endmodule

[design/assembly_source_tokenizer.sv]
// assembly source tokenizer
// input channel: in_valid / in_stall with char_code, one source byte per beat
// output channel: out_valid / out_stall with the token fields, one token per beat
// each byte may close a pending token and start another, giving zero to three
// tokens; last_of_run marks the final token caused by one byte
// a byte is taken in the cycle it arrives unless in_stall is high, and its
// tokens are registered in an eight-entry output queue before they reach the output
// throughput is one byte per cycle while the queue holds five or fewer tokens,
// in_stall rises when the queue is fuller, so a stalled receiver back-pressures
// the source and no token is lost
// a zero byte closes any open token, emits an end token and returns the
// scanner to its reset state
// reset clears the scanner state and empties the queue
module assembly_source_tokenizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  token_kind,
  output logic [15:0] token_value,
  output logic [15:0] start_offset,
  output logic [7:0]  token_length,
  output logic [15:0] row_number,
  output logic [15:0] column_number,
  output logic        last_of_run
);
  import ast_pkg::*;

  result_t    res [3];
  logic [1:0] res_n;
  logic       space_ok;
  logic       step;
  result_t    out_res;

  assign in_stall = !space_ok;
  assign step = in_valid && space_ok;

  ast_lexer u_lexer (
    .clk(clk), .rst(rst), .step(step), .c(char_code), .res(res), .res_n(res_n)
  );

  ast_outq u_outq (
    .clk(clk), .rst(rst), .push(step), .wr(res), .wr_n(res_n),
    .space_ok(space_ok), .out_valid(out_valid), .out_stall(out_stall),
    .out_res(out_res), .out_last(last_of_run)
  );

  assign token_kind = out_res.kind;
  assign token_value = out_res.value;
  assign start_offset = out_res.start;
  assign token_length = out_res.count;
  assign row_number = out_res.row;
  assign column_number = out_res.column;

  a_end_one: assert property (@(posedge clk) disable iff (rst)
    step && char_code == CH_NUL |-> res_n != 2'd0)
    else $error("zero byte gave no end token");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("stall with empty queue");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == K_END |-> last_of_run)
    else $error("end token not last of run");

endmodule
